[hw/rtl/bilinear_channel_resampler_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef BILINEAR_CHANNEL_RESAMPLER_TOP_MACROS_SVH
`define BILINEAR_CHANNEL_RESAMPLER_TOP_MACROS_SVH
`define BCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/bcr_pkg.sv]
package bcr_pkg;
	localparam int MAX_WIDTH_D = 256;
	localparam int MAX_HEIGHT_D = 256;
	localparam int FRAC_BITS_D = 16;
	localparam int SIZE_W = 9;
	localparam int RATIO_W = 25;
	localparam int POS_W = 8;
	localparam int PIX_W = 8;

	typedef enum logic [2:0] {
		REG_SRC_W = 3'd0,
		REG_SRC_H = 3'd1,
		REG_DST_W = 3'd2,
		REG_DST_H = 3'd3,
		REG_XR = 3'd4,
		REG_YR = 3'd5
	} reg_idx_t;

	typedef enum logic [0:0] {
		REQ_LOAD = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_ERROR = 2'd1,
		CMD_DIRECT = 2'd2,
		CMD_BLEND = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [PIX_W-1:0] pixel_value;
	} job_t;
endpackage

[hw/rtl/bcr_ram.sv]
module bcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[hw/rtl/bcr_front.sv]
module bcr_front import bcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic [POS_W-1:0] pos_x,
	input logic [POS_W-1:0] pos_y,
	input logic [PIX_W-1:0] pixel_value,
	input logic [SIZE_W-1:0] src_width,
	input logic [SIZE_W-1:0] src_height,
	input logic [SIZE_W-1:0] dst_width,
	input logic [SIZE_W-1:0] dst_height,
	output logic job_valid,
	input logic job_pop,
	output job_t job
);
	localparam int QD = 2;
	job_t q_q [QD];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic push;
	job_t nj;

	always_comb begin
		nj.pos_x = pos_x;
		nj.pos_y = pos_y;
		nj.pixel_value = pixel_value;
		if (req_t'(req_type) == REQ_LOAD) begin
			nj.cmd = CMD_LOAD;
		end else if ({1'b0, pos_x} >= dst_width || {1'b0, pos_y} >= dst_height) begin
			nj.cmd = CMD_ERROR;
		end else if (src_width == dst_width && src_height == dst_height) begin
			nj.cmd = CMD_DIRECT;
		end else begin
			nj.cmd = CMD_BLEND;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= nj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (job_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop};
		end
	end
endmodule

[hw/rtl/bcr_back.sv]
module bcr_back import bcr_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_D,
	parameter int MAX_HEIGHT = MAX_HEIGHT_D,
	parameter int FRAC_BITS = FRAC_BITS_D
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_pop,
	input job_t job,
	input logic [SIZE_W-1:0] src_width,
	input logic [SIZE_W-1:0] src_height,
	input logic [RATIO_W-1:0] x_step_ratio,
	input logic [RATIO_W-1:0] y_step_ratio,
	output logic out_valid,
	input logic out_stall,
	output logic [PIX_W-1:0] sample_value,
	output logic coord_error
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int TW = POS_W + 1 + RATIO_W;
	localparam int FW = TW - 1;
	localparam int PW = PIX_W + 1;
	localparam int LW = PIX_W + FRAC_BITS + 2;
	localparam int VW = PIX_W + 2 * FRAC_BITS + 3;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_MAP = 8'b00000010,
		ST_R0 = 8'b00000100,
		ST_R1 = 8'b00001000,
		ST_R2 = 8'b00010000,
		ST_R3 = 8'b00100000,
		ST_H = 8'b01000000,
		ST_V = 8'b10000000
	} st_t;

	st_t st_q;
	logic [FW-1:0] fx_q, fy_q;
	logic [XW-1:0] x0_q, x1_q;
	logic [YW-1:0] y0_q, y1_q;
	logic [FRAC_BITS-1:0] wx_q, wy_q;
	logic [PIX_W-1:0] p00_q, p01_q, p10_q;
	logic signed [LW-1:0] top_q, bot_q;
	logic direct_q;
	logic [PIX_W-1:0] res_q;
	logic err_q, ov_q;

	logic [SIZE_W-1:0] sw, sh;
	logic [AW-1:0] addr;
	logic we;
	logic [PIX_W-1:0] rdata;

	function automatic logic [SIZE_W-1:0] eff(input logic [SIZE_W-1:0] v, input int m);
		if (v == '0) return SIZE_W'(1);
		if (32'(v) > m) return SIZE_W'(m);
		return v;
	endfunction

	function automatic logic [FW-1:0] mapf(input logic [POS_W-1:0] d,
			input logic [RATIO_W-1:0] r);
		logic [TW-1:0] t;
		logic [TW-1:0] one;
		t = TW'({d, 1'b1}) * TW'(r);
		one = TW'(1) << FRAC_BITS;
		if (t <= one) return '0;
		return FW'((t - one) >> 1);
	endfunction

	assign sw = eff(src_width, MAX_WIDTH);
	assign sh = eff(src_height, MAX_HEIGHT);

	logic [FW-1:0] ipx, ipy;
	logic [SIZE_W-1:0] lx, ly;
	assign ipx = fx_q >> FRAC_BITS;
	assign ipy = fy_q >> FRAC_BITS;
	assign lx = sw - SIZE_W'(1);
	assign ly = sh - SIZE_W'(1);

	always_comb begin
		we = 1'b0;
		addr = {y0_q, x0_q};
		unique case (st_q)
			ST_IDLE: begin
				addr = {YW'(job.pos_y), XW'(job.pos_x)};
				we = job_valid && job.cmd == CMD_LOAD &&
					32'(job.pos_x) < MAX_WIDTH && 32'(job.pos_y) < MAX_HEIGHT;
			end
			ST_R0: addr = {y0_q, x0_q};
			ST_R1: addr = {y0_q, x1_q};
			ST_R2: addr = {y1_q, x0_q};
			ST_R3: addr = {y1_q, x1_q};
			default: addr = {y0_q, x0_q};
		endcase
	end

	bcr_ram #(.WIDTH(PIX_W), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(job.pixel_value), .rdata(rdata)
	);

	logic take;
	assign take = st_q == ST_IDLE && job_valid && !ov_q;
	assign job_pop = take;

	logic signed [LW-1:0] hmix;
	logic signed [VW-1:0] vsum;
	logic [VW-1:0] rnd;
	always_comb begin
		hmix = LW'(signed'({1'b0, p10_q})) <<< FRAC_BITS;
		hmix = hmix + LW'(signed'(PW'(rdata) - PW'(p10_q)) * signed'({1'b0, wx_q}));
		vsum = (VW'(top_q) <<< FRAC_BITS) +
			VW'((bot_q - top_q) * signed'({1'b0, wy_q}));
		rnd = VW'(vsum) + (VW'(1) << (2 * FRAC_BITS - 1));
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				fx_q <= mapf(job.pos_x, x_step_ratio);
				fy_q <= mapf(job.pos_y, y_step_ratio);
				x0_q <= (32'(job.pos_x) < 32'(sw)) ? XW'(job.pos_x) : XW'(sw - 1'b1);
				y0_q <= (32'(job.pos_y) < 32'(sh)) ? YW'(job.pos_y) : YW'(sh - 1'b1);
				direct_q <= job.cmd == CMD_DIRECT;
			end
			ST_MAP: begin
				if (!direct_q) begin
					if (32'(ipx) > 32'(lx)) begin
						x0_q <= XW'(lx);
						wx_q <= '0;
					end else begin
						x0_q <= XW'(ipx);
						wx_q <= FRAC_BITS'(fx_q);
					end
					x1_q <= (32'(ipx) + 1 < 32'(sw)) ? XW'(ipx + 1'b1) : XW'(lx);
					if (32'(ipy) > 32'(ly)) begin
						y0_q <= YW'(ly);
						wy_q <= '0;
					end else begin
						y0_q <= YW'(ipy);
						wy_q <= FRAC_BITS'(fy_q);
					end
					y1_q <= (32'(ipy) + 1 < 32'(sh)) ? YW'(ipy + 1'b1) : YW'(ly);
				end
			end
			ST_R0: ;
			ST_R1: p00_q <= rdata;
			ST_R2: begin
				p01_q <= rdata;
				res_q <= p00_q;
			end
			ST_R3: begin
				p10_q <= rdata;
				top_q <= (LW'(signed'({1'b0, p00_q})) <<< FRAC_BITS) +
					LW'(signed'(PW'(p01_q) - PW'(p00_q)) * signed'({1'b0, wx_q}));
			end
			ST_H: bot_q <= hmix;
			ST_V: begin
				if (vsum < 0) res_q <= '0;
				else if ((rnd >> (2 * FRAC_BITS)) > VW'(255)) res_q <= '1;
				else res_q <= PIX_W'(rnd >> (2 * FRAC_BITS));
			end
			default: ;
		endcase
		if (take && job.cmd == CMD_ERROR) begin
			res_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (take) begin
						if (job.cmd == CMD_ERROR) begin
							ov_q <= 1'b1;
							err_q <= 1'b1;
						end else if (job.cmd != CMD_LOAD) begin
							st_q <= ST_MAP;
						end
					end
				end
				ST_MAP: st_q <= ST_R0;
				ST_R0: st_q <= ST_R1;
				ST_R1: st_q <= ST_R2;
				ST_R2: begin
					if (direct_q) begin
						st_q <= ST_IDLE;
						ov_q <= 1'b1;
						err_q <= 1'b0;
					end else begin
						st_q <= ST_R3;
					end
				end
				ST_R3: st_q <= ST_H;
				ST_H: st_q <= ST_V;
				ST_V: begin
					st_q <= ST_IDLE;
					ov_q <= 1'b1;
					err_q <= 1'b0;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign sample_value = res_q;
	assign coord_error = err_q;
endmodule

[hw/rtl/bilinear_channel_resampler_top.sv]
// Bilinear resampler for one 8-bit image channel, half-pixel centers.
// Input channel: in_valid/in_stall with req_type, pos_x, pos_y, pixel_value.
// A load beat writes one source byte and gives no result. A sample beat
// gives one beat on the output channel: sample_value and coord_error.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// the user must keep to that, as the block does not enforce it. A
// two-entry queue sits between the classifier and the datapath, so input
// beats are taken while a result waits on a stalled receiver. A blend
// takes four sequential reads of the single-port source RAM plus the map
// and two blend steps. The datapath takes its next job in the cycle after
// the result beat leaves, so it never starts a sample while a result
// waits; loads go one per cycle while it is idle and no result waits.
// Results stay in order.
// When out_stall is high the result register holds and the datapath waits
// before taking its next job; the queue then fills and raises in_stall.
// Reset clears the queue and control state and restores the register
// defaults; the source RAM is not cleared and must be loaded before use.
module bilinear_channel_resampler_top import bcr_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_D,
	parameter int MAX_HEIGHT = MAX_HEIGHT_D,
	parameter int FRAC_BITS = FRAC_BITS_D
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [RATIO_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic [POS_W-1:0] pos_x,
	input logic [POS_W-1:0] pos_y,
	input logic [PIX_W-1:0] pixel_value,
	output logic out_valid,
	input logic out_stall,
	output logic [PIX_W-1:0] sample_value,
	output logic coord_error
);
	logic [SIZE_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [RATIO_W-1:0] xr_q, yr_q;
	logic job_valid, job_pop;
	job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SIZE_W'(256);
			src_h_q <= SIZE_W'(256);
			dst_w_q <= SIZE_W'(256);
			dst_h_q <= SIZE_W'(256);
			xr_q <= RATIO_W'(1) << FRAC_BITS;
			yr_q <= RATIO_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data[SIZE_W-1:0];
				REG_SRC_H: src_h_q <= cfg_data[SIZE_W-1:0];
				REG_DST_W: dst_w_q <= cfg_data[SIZE_W-1:0];
				REG_DST_H: dst_h_q <= cfg_data[SIZE_W-1:0];
				REG_XR: xr_q <= cfg_data;
				REG_YR: yr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bcr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .pixel_value(pixel_value),
		.src_width(src_w_q), .src_height(src_h_q), .dst_width(dst_w_q),
		.dst_height(dst_h_q), .job_valid(job_valid), .job_pop(job_pop), .job(job)
	);

	bcr_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS))
	u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_pop(job_pop),
		.job(job), .src_width(src_w_q), .src_height(src_h_q),
		.x_step_ratio(xr_q), .y_step_ratio(yr_q), .out_valid(out_valid),
		.out_stall(out_stall), .sample_value(sample_value), .coord_error(coord_error)
	);
endmodule

[hw/rtl/bcr_checker.sv]
`include "bilinear_channel_resampler_top_macros.svh"
module bcr_checker import bcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [PIX_W-1:0] sample_value,
	input logic coord_error
);
	`BCR_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && coord_error, sample_value == '0)
	`BCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(sample_value) && $stable(coord_error))
	`BCR_ASSERT_NEXT(a_stall_clear, clk, arst_n, in_stall && !out_valid && !in_valid,
		!in_stall || !$past(in_valid))
endmodule

bind bilinear_channel_resampler_top bcr_checker u_bcr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .sample_value(sample_value),
	.coord_error(coord_error)
);

[tb/sv/bilinear_channel_resampler_top_tb.sv]
`timescale 1ns / 1ps
module bilinear_channel_resampler_top_tb;
	import bcr_pkg::*;

	localparam int ONE = 1 << FRAC_BITS_D;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic flag;
	} sample_res_t;

	typedef struct {
		req_t kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [PIX_W-1:0] pix;
		bit known;
		sample_res_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [RATIO_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [POS_W-1:0] pos_x = '0;
	logic [POS_W-1:0] pos_y = '0;
	logic [PIX_W-1:0] pixel_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] sample_value;
	logic coord_error;

	bilinear_channel_resampler_top u_top (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	logic [PIX_W-1:0] image [0:MAX_WIDTH_D*MAX_HEIGHT_D-1];
	logic [SIZE_W-1:0] src_w, src_h, dst_w, dst_h;
	logic [RATIO_W-1:0] x_ratio, y_ratio;
	sample_res_t pending_samples [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;

	function automatic int clamp_size(logic [SIZE_W-1:0] v);
		if (v == 0) return 1;
		return (v > 256) ? 256 : int'(v);
	endfunction

	function automatic void map_coord(int d, longint ratio, int size,
			output int i0, output int i1, output longint w);
		longint t, f, ip;
		t = longint'(2 * d + 1) * ratio;
		f = (t <= ONE) ? 0 : ((t - ONE) >>> 1);
		ip = f >>> FRAC_BITS_D;
		w = f & (ONE - 1);
		if (ip > size - 1) begin
			ip = size - 1;
			w = 0;
		end
		i0 = int'(ip);
		i1 = (i0 + 1 < size) ? i0 + 1 : size - 1;
	endfunction

	function automatic longint px_at(int x, int y);
		return longint'(image[y * MAX_WIDTH_D + x]);
	endfunction

	function automatic sample_res_t resample(int x, int y);
		sample_res_t r;
		int sw, sh, x0, x1, y0, y1;
		longint wx, wy, top, bot, v, q;
		r = '0;
		if (x >= dst_w || y >= dst_h) begin
			r.flag = 1'b1;
			return r;
		end
		sw = clamp_size(src_w);
		sh = clamp_size(src_h);
		if (src_w == dst_w && src_h == dst_h) begin
			r.value = PIX_W'(px_at(x < sw ? x : sw - 1, y < sh ? y : sh - 1));
			return r;
		end
		map_coord(x, longint'(x_ratio), sw, x0, x1, wx);
		map_coord(y, longint'(y_ratio), sh, y0, y1, wy);
		top = px_at(x0, y0) * ONE + (px_at(x1, y0) - px_at(x0, y0)) * wx;
		bot = px_at(x0, y1) * ONE + (px_at(x1, y1) - px_at(x0, y1)) * wx;
		v = top * ONE + (bot - top) * wy;
		if (v < 0) v = 0;
		q = (v + (longint'(1) << (2 * FRAC_BITS_D - 1))) >>> (2 * FRAC_BITS_D);
		r.value = (q > 255) ? 8'd255 : q[7:0];
		return r;
	endfunction

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= RATIO_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_W: src_w = SIZE_W'(val);
			REG_SRC_H: src_h = SIZE_W'(val);
			REG_DST_W: dst_w = SIZE_W'(val);
			REG_DST_H: dst_h = SIZE_W'(val);
			REG_XR: x_ratio = RATIO_W'(val);
			REG_YR: y_ratio = RATIO_W'(val);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_beat(req_t kind, int x, int y, int pix, bit known,
			sample_res_t res);
		sample_res_t exp_res;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		pos_x <= POS_W'(x);
		pos_y <= POS_W'(y);
		pixel_value <= PIX_W'(pix);
		do @(posedge clk); while (in_stall);
		if (kind == REQ_LOAD) begin
			image[y * MAX_WIDTH_D + x] = PIX_W'(pix);
		end else begin
			exp_res = resample(x, y);
			if (known && exp_res !== res) begin
				errors++;
				if (errors <= 10)
					$display("table row at (%0d,%0d): expected %0d/%0b predicted %0d/%0b",
						x, y, res.value, res.flag, exp_res.value, exp_res.flag);
			end
			pending_samples.insert(pending_samples.size(), exp_res);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	always @(posedge clk) begin
		sample_res_t exp_res;
		if (arst_n) begin
			out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (pending_samples.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result beat %0d", sample_value);
				end else begin
					exp_res = pending_samples.pop_front();
					if (sample_value !== exp_res.value || coord_error !== exp_res.flag) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %0d/%0b got %0d/%0b",
								exp_res.value, exp_res.flag, sample_value, coord_error);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Fill the whole source area so every sample reads written entries.
	task automatic fill_source(int w, int h);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				send_beat(REQ_LOAD, x, y, $urandom_range(255), 0, '0);
	endtask

	task automatic set_sizes(int sw, int sh, int dw, int dh);
		write_reg(REG_SRC_W, sw);
		write_reg(REG_SRC_H, sh);
		write_reg(REG_DST_W, dw);
		write_reg(REG_DST_H, dh);
		write_reg(REG_XR, ((sw == 0 ? 1 : sw) * ONE) / (dw == 0 ? 1 : dw));
		write_reg(REG_YR, ((sh == 0 ? 1 : sh) * ONE) / (dh == 0 ? 1 : dh));
	endtask

	task automatic random_phase(int n, int sw, int sh);
		int x, y;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				x = $urandom_range(255);
				y = $urandom_range(255);
				if (x >= sw || y >= sh) send_beat(REQ_LOAD, x, y, $urandom_range(255), 0, '0);
				else send_beat(REQ_LOAD, x, y, $urandom_range(255), 0, '0);
			end else begin
				x = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(dst_w + 1);
				y = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(dst_h + 1);
				send_beat(REQ_SAMPLE, x & 255, y & 255, $urandom_range(255), 0, '0);
			end
		end
	endtask

	stim_row_t plan [9];
	int dir_pcts [4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{32, 32}};

	initial begin
		src_w = 256; src_h = 256; dst_w = 256; dst_h = 256;
		x_ratio = ONE; y_ratio = ONE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small source, identity sizes first, then directed corners.
		set_sizes(4, 4, 4, 4);
		fill_source(4, 4);
		plan = '{
			'{REQ_LOAD, 8'd0, 8'd0, 8'd0, 0, '0},
			'{REQ_LOAD, 8'd3, 8'd3, 8'd255, 0, '0},
			'{REQ_LOAD, 8'd255, 8'd255, 8'd170, 0, '0},
			'{REQ_SAMPLE, 8'd0, 8'd0, 8'd85, 1, '{8'd0, 1'b0}},
			'{REQ_SAMPLE, 8'd3, 8'd3, 8'd0, 1, '{8'd255, 1'b0}},
			'{REQ_SAMPLE, 8'd4, 8'd0, 8'd0, 1, '{8'd0, 1'b1}},
			'{REQ_SAMPLE, 8'd0, 8'd4, 8'd0, 1, '{8'd0, 1'b1}},
			'{REQ_SAMPLE, 8'd255, 8'd255, 8'd255, 1, '{8'd0, 1'b1}},
			'{REQ_SAMPLE, 8'd2, 8'd1, 8'd0, 0, '0}
		};
		foreach (plan[i])
			send_beat(plan[i].kind, plan[i].x, plan[i].y, plan[i].pix, plan[i].known,
				plan[i].res);
		drain();

		set_sizes(4, 4, 7, 3);
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 7; x++) send_beat(REQ_SAMPLE, x, y, 0, 0, '0);
		drain();
		set_sizes(4, 4, 0, 0);
		send_beat(REQ_SAMPLE, 0, 0, 0, 1, '{8'd0, 1'b1});
		drain();
		write_reg(REG_DST_W, 2); write_reg(REG_DST_H, 2);
		write_reg(REG_XR, 1 << 24); write_reg(REG_YR, 256);
		send_beat(REQ_SAMPLE, 1, 1, 0, 0, '0);
		send_beat(REQ_SAMPLE, 0, 0, 0, 0, '0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = dir_pcts[ph][0];
			recv_stall_pct = dir_pcts[ph][1];
			case (ph)
				0: set_sizes(4, 4, 9, 6);
				1: set_sizes(1, 1, 3, 5);
				2: set_sizes(16, 12, 5, 7);
				default: set_sizes(16, 16, 30, 11);
			endcase
			fill_source(clamp_size(src_w), clamp_size(src_h));
			random_phase(125, clamp_size(src_w), clamp_size(src_h));
			drain();
		end

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
